/* sv/cbse_pkg.sv */
// Shared constants, codes and controller/datapath interface types for the circle stamp engine.
package cbse_pkg;

  // Screen geometry and brush limit.
  localparam int unsigned CANVAS_COLS = 800;
  localparam int unsigned CANVAS_ROWS = 480;
  localparam int unsigned MAX_RADIUS  = 63;
  localparam int unsigned PIXEL_TOTAL = CANVAS_COLS * CANVAS_ROWS;

  // Field widths.
  localparam int unsigned ACTION_W = 2;
  localparam int unsigned X_W      = 10;
  localparam int unsigned Y_W      = 9;
  localparam int unsigned RAD_W    = 6;
  localparam int unsigned COLOR_W  = 16;
  localparam int unsigned ADDR_W   = 19;
  localparam int unsigned COUNT_W  = 14;

  // Internal widths: signed offsets, their squares, signed target coordinates.
  localparam int unsigned OFF_W = RAD_W + 1;
  localparam int unsigned SQ_W  = 2 * OFF_W;
  localparam int unsigned XS_W  = X_W + 2;
  localparam int unsigned YS_W  = Y_W + 2;

  // Configuration port.
  localparam int unsigned PADDR_W   = 3;
  localparam int unsigned PDATA_W   = 32;
  localparam logic        REG_ERASER = 1'b0;

  typedef enum logic [ACTION_W-1:0] {
    ACT_STAMP = 2'd0,
    ACT_WRITE = 2'd1,
    ACT_READ  = 2'd2
  } action_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_SCAN,
    ST_DRAIN,
    ST_FINISH
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic run;
    logic wr_pixel;
  } cbse_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    action_e action;
    logic    radius_zero;
    logic    scan_last;
    logic    pipe_busy;
  } cbse_sts_t;

endpackage

/* sv/circle_brush_stamp_engine.sv */
// Top level of the circle stamp engine: configuration port, output register and assertions.
//
// Usage:
//   Items enter on the input channel (in_valid_i, in_stall_o) with fields action_i,
//   center_x_i, center_y_i, radius_i, color_i and address_i. Each item gives exactly
//   one result transaction on the output channel (out_valid_o, out_stall_i) carrying
//   read_pixel_o and write_count_o.
//   A write item stores color_i at address_i in both the canvas and the background
//   memories. A read item returns the canvas pixel. A stamp item scans 2r by 2r
//   offsets, one per cycle, and paints (or restores the background when color_i
//   equals eraser_color) every pixel inside the circle, clamped to the screen.
//   For write, read, unused actions and radius-zero stamps the controller steps through
//   DECODE and FINISH before the result is registered; a stamp of nonzero radius also
//   passes SCAN and DRAIN in between. The next item can be accepted once the result is
//   registered, so items are worked one at a time.
//   The input is taken again as soon as a result is in the output register, so a
//   stalled receiver only holds back the next result, not the next acceptance.
//   Reset clears the controller, the pipeline and eraser_color; memory contents are
//   undefined until written, and no clearing pass runs. The user must write eraser_color
//   through the APB port at byte address 0 while idle; the block does not enforce this.
module circle_brush_stamp_engine
  import cbse_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  // Configuration port.
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  // Input channel.
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [ACTION_W-1:0] action_i,
  input  logic [X_W-1:0]     center_x_i,
  input  logic [Y_W-1:0]     center_y_i,
  input  logic [RAD_W-1:0]   radius_i,
  input  logic [COLOR_W-1:0] color_i,
  input  logic [ADDR_W-1:0]  address_i,
  // Output channel.
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [COLOR_W-1:0] read_pixel_o,
  output logic [COUNT_W-1:0] write_count_o
);

  logic [COLOR_W-1:0] eraser_color_q;
  logic               out_valid_q;
  logic [COLOR_W-1:0] read_pixel_q;
  logic [COUNT_W-1:0] write_count_q;
  logic               out_free;
  logic               out_load;
  logic [COLOR_W-1:0] res_pixel;
  logic [COUNT_W-1:0] res_count;
  cbse_cmd_t          cmd;
  cbse_sts_t          sts;

  // Configuration register.
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      eraser_color_q <= '0;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_ERASER) begin
      eraser_color_q <= pwdata[COLOR_W-1:0];
    end
  end

  assign prdata = (paddr[2] == REG_ERASER) ? PDATA_W'(eraser_color_q) : '0;

  // Controller.
  cbse_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .out_free_i (out_free),
    .out_load_o (out_load),
    .cmd_o      (cmd),
    .sts_i      (sts)
  );

  // Datapath.
  cbse_dpath u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .action_i       (action_i),
    .center_x_i     (center_x_i),
    .center_y_i     (center_y_i),
    .radius_i       (radius_i),
    .color_i        (color_i),
    .address_i      (address_i),
    .eraser_color_i (eraser_color_q),
    .res_pixel_o    (res_pixel),
    .res_count_o    (res_count)
  );

  // Output register: holds one result transaction until the receiver takes it.
  assign out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      read_pixel_q  <= res_pixel;
      write_count_q <= res_count;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign read_pixel_o  = read_pixel_q;
  assign write_count_o = write_count_q;

  // A new item is only taken when the stamp pipeline is empty.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_stall_o |-> !sts.pipe_busy)
    else $error("input accepted while stamp pipeline busy");

  // A result never overwrites one the receiver has not taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> (!out_valid_q || !out_stall_i))
    else $error("result register overwritten");

  // After acceptance the block works on that item before taking another.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("second item accepted back to back");

  // Only a stamp reports canvas writes.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load && (sts.action != ACT_STAMP) |=> (write_count_q == '0))
    else $error("write count reported for a non-stamp item");

endmodule

/* sv/cbse_ctrl.sv */
// Controller state machine that sequences item capture, the stamp scan and result hand-off.
module cbse_ctrl
  import cbse_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  logic      out_free_i,
  output logic      out_load_o,
  output cbse_cmd_t cmd_o,
  input  cbse_sts_t sts_i
);

  state_e state_q, state_d;

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands.
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    out_load_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_DECODE;
        end
      end
      ST_DECODE: begin
        case (sts_i.action)
          ACT_STAMP: begin
            state_d = sts_i.radius_zero ? ST_FINISH : ST_SCAN;
          end
          ACT_WRITE: begin
            cmd_o.wr_pixel = 1'b1;
            state_d        = ST_FINISH;
          end
          default: begin
            state_d = ST_FINISH;
          end
        endcase
      end
      ST_SCAN: begin
        cmd_o.run = 1'b1;
        if (sts_i.scan_last) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!sts_i.pipe_busy) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (out_free_i) begin
          out_load_o = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

/* sv/cbse_dpath.sv */
// Datapath: item registers, offset counters, stamp pipeline and the two pixel memories.
module cbse_dpath
  import cbse_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cbse_cmd_t          cmd_i,
  output cbse_sts_t          sts_o,
  input  logic [ACTION_W-1:0] action_i,
  input  logic [X_W-1:0]     center_x_i,
  input  logic [Y_W-1:0]     center_y_i,
  input  logic [RAD_W-1:0]   radius_i,
  input  logic [COLOR_W-1:0] color_i,
  input  logic [ADDR_W-1:0]  address_i,
  input  logic [COLOR_W-1:0] eraser_color_i,
  output logic [COLOR_W-1:0] res_pixel_o,
  output logic [COUNT_W-1:0] res_count_o
);

  // Captured item.
  action_e                   action_q;
  logic [X_W-1:0]            cx_q;
  logic [Y_W-1:0]            cy_q;
  logic [RAD_W-1:0]          rad_q;
  logic [SQ_W-1:0]           r2_q;
  logic signed [OFF_W-1:0]   neg_r_q;
  logic signed [OFF_W-1:0]   rm1_q;
  logic [COLOR_W-1:0]        color_q;
  logic [ADDR_W-1:0]         address_q;
  logic                      erase_q;

  // Offset counters.
  logic signed [OFF_W-1:0]   i_q, j_q;

  // Stamp pipeline.
  logic                      s1_v_q, s2_v_q;
  logic                      s1_hit_q;
  logic [ADDR_W-1:0]         s1_addr_q, s2_addr_q;
  logic [COLOR_W-1:0]        bg_rd_q;
  logic [COLOR_W-1:0]        canvas_rd_q;
  logic [COUNT_W-1:0]        count_q;

  // Memories.
  logic [COLOR_W-1:0]        canvas_mem [PIXEL_TOTAL];
  logic [COLOR_W-1:0]        bg_mem     [PIXEL_TOTAL];

  logic [RAD_W-1:0]          rad_eff;
  logic                      addr_ok;
  logic                      i_last, j_last;
  logic [SQ_W-1:0]           i_sq, j_sq;
  logic [SQ_W:0]             sq_sum;
  logic                      hit;
  logic signed [XS_W-1:0]    tx_s;
  logic signed [YS_W-1:0]    ty_s;
  logic [X_W-1:0]            tx;
  logic [Y_W-1:0]            ty;
  logic [ADDR_W-1:0]         pos;
  logic                      cv_we;
  logic [ADDR_W-1:0]         cv_wa;
  logic [COLOR_W-1:0]        cv_wd;

  // Radius saturation and address range check.
  assign rad_eff = (radius_i > RAD_W'(MAX_RADIUS)) ? RAD_W'(MAX_RADIUS) : radius_i;
  assign addr_ok = (address_q < ADDR_W'(PIXEL_TOTAL));

  // Item capture.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      action_q  <= action_e'(action_i);
      cx_q      <= center_x_i;
      cy_q      <= center_y_i;
      rad_q     <= rad_eff;
      r2_q      <= SQ_W'(rad_eff) * SQ_W'(rad_eff);
      neg_r_q   <= -$signed({1'b0, rad_eff});
      rm1_q     <= $signed({1'b0, rad_eff}) - OFF_W'(1);
      color_q   <= color_i;
      address_q <= address_i;
      erase_q   <= (color_i == eraser_color_i);
    end
  end

  // Offset counters: j is the outer loop, i the inner one.
  assign i_last = (i_q == rm1_q);
  assign j_last = (j_q == rm1_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      i_q <= -$signed({1'b0, rad_eff});
      j_q <= -$signed({1'b0, rad_eff});
    end else if (cmd_i.run) begin
      if (i_last) begin
        i_q <= neg_r_q;
        j_q <= j_q + OFF_W'(1);
      end else begin
        i_q <= i_q + OFF_W'(1);
      end
    end
  end

  // Inside test on the current offsets.
  assign i_sq   = SQ_W'(i_q * i_q);
  assign j_sq   = SQ_W'(j_q * j_q);
  assign sq_sum = {1'b0, i_sq} + {1'b0, j_sq};
  assign hit    = (sq_sum <= {1'b0, r2_q});

  // Clamped target coordinates and linear pixel address.
  assign tx_s = $signed({2'b00, cx_q}) + XS_W'(i_q);
  assign ty_s = $signed({2'b00, cy_q}) + YS_W'(j_q);

  always_comb begin
    if (tx_s < 0) begin
      tx = '0;
    end else if (tx_s >= $signed(XS_W'(CANVAS_COLS))) begin
      tx = X_W'(CANVAS_COLS - 1);
    end else begin
      tx = tx_s[X_W-1:0];
    end
    if (ty_s < 0) begin
      ty = '0;
    end else if (ty_s >= $signed(YS_W'(CANVAS_ROWS))) begin
      ty = Y_W'(CANVAS_ROWS - 1);
    end else begin
      ty = ty_s[Y_W-1:0];
    end
  end

  assign pos = ADDR_W'(ADDR_W'(ty) * ADDR_W'(CANVAS_COLS)) + ADDR_W'(tx);

  // Pipeline valid bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
    end else begin
      s1_v_q <= cmd_i.run;
      s2_v_q <= s1_v_q && s1_hit_q;
    end
  end

  // Pipeline payload.
  always_ff @(posedge clk_i) begin
    s1_hit_q  <= hit;
    s1_addr_q <= pos;
    s2_addr_q <= s1_addr_q;
  end

  // Write counter for the current stamp.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (cmd_i.load) begin
      count_q <= '0;
    end else if (s2_v_q) begin
      count_q <= count_q + COUNT_W'(1);
    end
  end

  // Background memory: loaded by write items, read by the stamp pipeline.
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_pixel && addr_ok) begin
      bg_mem[address_q] <= color_q;
    end
    bg_rd_q <= bg_mem[s1_addr_q];
  end

  // Canvas write port: stamp writes and write items never overlap.
  assign cv_we = s2_v_q || (cmd_i.wr_pixel && addr_ok);
  assign cv_wa = s2_v_q ? s2_addr_q : address_q;
  assign cv_wd = (s2_v_q && erase_q) ? bg_rd_q : color_q;

  always_ff @(posedge clk_i) begin
    if (cv_we) begin
      canvas_mem[cv_wa] <= cv_wd;
    end
    canvas_rd_q <= canvas_mem[address_q];
  end

  // Status and results.
  assign sts_o.action      = action_q;
  assign sts_o.radius_zero = (rad_q == '0);
  assign sts_o.scan_last   = i_last && j_last;
  assign sts_o.pipe_busy   = s1_v_q || s2_v_q;

  assign res_pixel_o = (action_q == ACT_READ && addr_ok) ? canvas_rd_q : '0;
  assign res_count_o = (action_q == ACT_STAMP) ? count_q : '0;

endmodule

/* tb/tb_circle_brush_stamp_engine.sv */
// Self-checking testbench for the circle brush stamp engine with a canvas predictor.
module tb_circle_brush_stamp_engine;
  import cbse_pkg::*;

  localparam int CLK_PERIOD     = 10;
  localparam int SCR_W          = CANVAS_COLS;
  localparam int SCR_H          = CANVAS_ROWS;
  localparam int PIX_N          = PIXEL_TOTAL;
  localparam int MAX_R          = MAX_RADIUS;
  localparam int ADDR_SPAN      = 1 << ADDR_W;
  localparam int X_SPAN         = 1 << X_W;
  localparam int Y_SPAN         = 1 << Y_W;
  localparam int ITEM_GOAL      = 1150;
  localparam int WATCHDOG_LIMIT = 80000;
  localparam int SETTLE_CYCLES  = 20;
  localparam int PRINT_CAP      = 40;
  localparam int HOT_COUNT      = 3;
  localparam int HOT_SIZE       = 24;
  // Small windows where backgrounds get loaded, so restoring stamps can land there.
  localparam int HOT_X [HOT_COUNT] = '{0, 776, 388};
  localparam int HOT_Y [HOT_COUNT] = '{0, 456, 228};

  localparam logic [ACTION_W-1:0] ACT_UNUSED  = 2'd3;
  localparam logic [PADDR_W-1:0]  ERASER_ADDR = PADDR_W'(4 * int'(REG_ERASER));

  typedef struct {
    bit [ACTION_W-1:0] act;
    bit [X_W-1:0]      cx;
    bit [Y_W-1:0]      cy;
    bit [RAD_W-1:0]    rad;
    bit [COLOR_W-1:0]  color;
    bit [ADDR_W-1:0]   addr;
  } brush_item_t;

  typedef struct {
    bit [COLOR_W-1:0] pixel;
    bit [COUNT_W-1:0] count;
    int unsigned      seq;
  } pixel_result_t;

  // Canvas and background predictor plus the queue of results still to arrive.
  class canvas_scoreboard;
    bit [COLOR_W-1:0] canvas [PIX_N];
    bit [COLOR_W-1:0] background [PIX_N];
    bit               canvas_set [PIX_N];
    bit               background_set [PIX_N];
    bit [COLOR_W-1:0] eraser;
    int               missing_pixels [$];
    pixel_result_t    expected_results [$];
    int unsigned      items_noted;
    int unsigned      n_stamps;
    int unsigned      n_restores;
    int unsigned      n_writes;
    int unsigned      n_reads;
    int unsigned      n_checked;
    longint unsigned  pixels_painted;

    function int clamp_to(int v, int lim);
      if (v < 0) return 0;
      if (v >= lim) return lim - 1;
      return v;
    endfunction

    function int pixel_at(int x, int y);
      return clamp_to(x, SCR_W) + clamp_to(y, SCR_H) * SCR_W;
    endfunction

    // Walks the brush footprint. With commit set it paints or restores the canvas and
    // returns the write count; otherwise it lists the targets with no background yet.
    function int unsigned visit_footprint(int cx, int cy, int r, bit [COLOR_W-1:0] color,
                                          bit commit);
      int unsigned hits;
      int          pos;
      bit          restore;
      hits    = 0;
      restore = (color == eraser);
      if (!commit) missing_pixels.delete();
      if (r > MAX_R) r = MAX_R;
      for (int j = -r; j < r; j++) begin
        for (int i = -r; i < r; i++) begin
          if (i * i + j * j <= r * r) begin
            pos = pixel_at(cx + i, cy + j);
            if (commit) begin
              canvas[pos]     = restore ? background[pos] : color;
              canvas_set[pos] = 1'b1;
              hits++;
            end else if (!background_set[pos]) begin
              missing_pixels.push_back(pos);
              hits++;
            end
          end
        end
      end
      return hits;
    endfunction

    // Applies one accepted input transaction and queues the result it must produce.
    function void note_item(brush_item_t it);
      pixel_result_t res;
      int unsigned   hits;
      res.pixel = '0;
      res.count = '0;
      res.seq   = items_noted++;
      case (it.act)
        ACT_STAMP: begin
          n_stamps++;
          if (it.color == eraser) n_restores++;
          hits = visit_footprint(int'(it.cx), int'(it.cy), int'(it.rad), it.color, 1'b1);
          pixels_painted += hits;
          res.count = hits[COUNT_W-1:0];
        end
        ACT_WRITE: begin
          n_writes++;
          if (it.addr < PIX_N) begin
            canvas[it.addr]         = it.color;
            background[it.addr]     = it.color;
            canvas_set[it.addr]     = 1'b1;
            background_set[it.addr] = 1'b1;
          end
        end
        ACT_READ: begin
          n_reads++;
          if (it.addr < PIX_N) res.pixel = canvas[it.addr];
        end
        default: ;
      endcase
      expected_results.push_back(res);
    endfunction

    // Compares one output transaction with the oldest prediction.
    function bit check_result(logic [COLOR_W-1:0] pixel, logic [COUNT_W-1:0] count,
                              output string why);
      pixel_result_t want;
      why = "";
      if (expected_results.size() == 0) begin
        why = $sformatf("unexpected result read_pixel=%h write_count=%0d", pixel, count);
        return 1'b0;
      end
      want = expected_results.pop_front();
      n_checked++;
      if (pixel !== want.pixel || count !== want.count) begin
        why = $sformatf("transaction %0d: pixel %h (want %h), count %0d (want %0d)",
                        want.seq, pixel, want.pixel, count, want.count);
        return 1'b0;
      end
      return 1'b1;
    endfunction
  endclass

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic               pready;
  logic               in_valid_i;
  logic               in_stall_o;
  logic [ACTION_W-1:0] action_i;
  logic [X_W-1:0]     center_x_i;
  logic [Y_W-1:0]     center_y_i;
  logic [RAD_W-1:0]   radius_i;
  logic [COLOR_W-1:0] color_i;
  logic [ADDR_W-1:0]  address_i;
  logic               out_valid_o;
  logic               out_stall_i;
  logic [COLOR_W-1:0] read_pixel_o;
  logic [COUNT_W-1:0] write_count_o;

  canvas_scoreboard  sb;
  int unsigned       items_sent = 0;
  int unsigned       mismatches = 0;
  int unsigned       eraser_settings = 0;
  int unsigned       send_idle_pct = 0;
  int unsigned       recv_idle_pct = 0;
  int unsigned       quiet_cycles = 0;
  bit [ADDR_W-1:0]   last_write_addr = '0;

  circle_brush_stamp_engine u_dut (.*);

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  task automatic report_mismatch(string why);
    mismatches++;
    if (mismatches <= PRINT_CAP) $display("MISMATCH %0d: %s", mismatches, why);
  endtask

  // Result side: check each output transaction and stall at random.
  always @(posedge clk_i) begin : result_monitor
    string why;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (!sb.check_result(read_pixel_o, write_count_o, why)) report_mismatch(why);
      end
      out_stall_i <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Ends the run when no transaction moves on either channel for too long.
  always @(posedge clk_i) begin : watchdog
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Watchdog expired after %0d cycles without a transaction", quiet_cycles);
      $display("Mismatches found");
      $finish;
    end
  end

  // Offers one input transaction, with random idle cycles ahead of it, and waits for it.
  task automatic send_item(bit [ACTION_W-1:0] act, bit [X_W-1:0] cx, bit [Y_W-1:0] cy,
                           bit [RAD_W-1:0] rad, bit [COLOR_W-1:0] color,
                           bit [ADDR_W-1:0] addr);
    brush_item_t it;
    it = '{act, cx, cy, rad, color, addr};
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    action_i   <= act;
    center_x_i <= cx;
    center_y_i <= cy;
    radius_i   <= rad;
    color_i    <= color;
    address_i  <= addr;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    sb.note_item(it);
    items_sent++;
    if (act == ACT_WRITE && addr < PIX_N) last_write_addr = addr;
  endtask

  // A stamp whose color would restore an unloaded background is nudged off the eraser.
  task automatic send_stamp(int cx, int cy, int r, bit [COLOR_W-1:0] color);
    if (color == sb.eraser && sb.visit_footprint(cx, cy, r, color, 1'b0) != 0) begin
      color = color ^ COLOR_W'(1);
    end
    send_item(ACT_STAMP, X_W'(cx), Y_W'(cy), RAD_W'(r), color, ADDR_W'($urandom));
  endtask

  // Writes the eraser color over APB and reads it back.
  task automatic set_eraser(bit [COLOR_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ERASER_ADDR;
    pwdata  <= PDATA_W'(value);
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    if (prdata[COLOR_W-1:0] !== value) begin
      report_mismatch($sformatf("eraser_color reads back %h, written %h",
                                prdata[COLOR_W-1:0], value));
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    sb.eraser = value;
    eraser_settings++;
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (sb.expected_results.size() != 0) @(posedge clk_i);
  endtask

  function automatic int hot_pixel();
    int h;
    h = $urandom_range(HOT_COUNT - 1);
    return sb.pixel_at(HOT_X[h] + $urandom_range(HOT_SIZE - 1),
                       HOT_Y[h] + $urandom_range(HOT_SIZE - 1));
  endfunction

  // Picks a read address that is either loaded already or past the end of the store.
  function automatic bit [ADDR_W-1:0] pick_read_addr();
    int a;
    if ($urandom_range(99) < 15) return ADDR_W'($urandom_range(ADDR_SPAN - 1, PIX_N));
    for (int k = 0; k < 8; k++) begin
      a = ($urandom_range(1) == 1) ? hot_pixel() : int'($urandom_range(PIX_N - 1));
      if (sb.canvas_set[a]) return ADDR_W'(a);
    end
    return last_write_addr;
  endfunction

  // Mostly small brushes, a few up to the largest radius.
  function automatic int pick_radius();
    int q;
    q = $urandom_range(99);
    if (q < 60) return $urandom_range(6);
    if (q < 90) return $urandom_range(20, 7);
    if (q < 97) return $urandom_range(40, 21);
    return $urandom_range(MAX_R, 41);
  endfunction

  task automatic run_directed();
    // Loads, reads, out-of-range addresses and the unused action.
    send_item(ACT_WRITE, '0, '0, '0, 16'hFFFF, '0);
    send_item(ACT_WRITE, '0, '0, '0, 16'h0000, ADDR_W'(PIX_N - 1));
    send_item(ACT_WRITE, '0, '0, '0, 16'hA5A5, ADDR_W'(1));
    send_item(ACT_WRITE, '0, '0, '0, 16'h5A5A, ADDR_W'(SCR_W));
    send_item(ACT_READ, '0, '0, '0, '0, '0);
    send_item(ACT_READ, '0, '0, '0, '0, ADDR_W'(PIX_N - 1));
    send_item(ACT_WRITE, '0, '0, '0, 16'h1234, '1);
    send_item(ACT_READ, '0, '0, '0, '0, '1);
    send_item(ACT_READ, '0, '0, '0, '0, ADDR_W'(PIX_N));
    send_item(ACT_UNUSED, '1, '1, '1, '1, '1);
    // Zero radius, clamped duplicates at the corner, and a restoring stamp.
    send_item(ACT_STAMP, '1, '1, '0, 16'h0000, '0);
    send_item(ACT_STAMP, '0, '0, RAD_W'(1), 16'h1234, '0);
    send_item(ACT_READ, '0, '0, '0, '0, '0);
    send_item(ACT_STAMP, '0, '0, RAD_W'(1), 16'h0000, '0);
    send_item(ACT_READ, '0, '0, '0, '0, '0);
    // Center off the screen piles up on the far corner.
    send_item(ACT_STAMP, '1, '1, RAD_W'(2), 16'hF800, '0);
    send_item(ACT_READ, '0, '0, '0, '0, ADDR_W'(PIX_N - 1));
    // Largest brush in the middle and against the edges.
    send_item(ACT_STAMP, X_W'(400), Y_W'(240), RAD_W'(MAX_R), 16'h07E0, '0);
    send_item(ACT_STAMP, '0, '0, RAD_W'(MAX_R), 16'h001F, '0);
    send_item(ACT_READ, '0, '0, '0, '0, ADDR_W'(400 + 240 * SCR_W));
    send_item(ACT_READ, '0, '0, '0, '0, ADDR_W'(SCR_W));
    send_item(ACT_STAMP, '1, '0, RAD_W'(32), 16'hFFFF, '0);
  endtask

  // Brush session: load the background under a spot, paint over it, restore it, read back.
  task automatic send_brush_session();
    int h;
    int cx;
    int cy;
    int r;
    int a;
    int holes [$];
    h  = $urandom_range(HOT_COUNT - 1);
    cx = HOT_X[h] + 4 + $urandom_range(HOT_SIZE - 9);
    cy = HOT_Y[h] + 4 + $urandom_range(HOT_SIZE - 9);
    // Corner windows also take centers near or beyond the screen edge.
    if (h == 1 && $urandom_range(1) == 1) begin
      cx = $urandom_range(X_SPAN - 1, 780);
      cy = $urandom_range(Y_SPAN - 1, 460);
    end
    if (h == 0 && $urandom_range(1) == 1) begin
      cx = $urandom_range(3);
      cy = $urandom_range(3);
    end
    r = ($urandom_range(3) == 0) ? int'($urandom_range(8, 4)) : int'($urandom_range(3, 1));
    if (sb.visit_footprint(cx, cy, r, sb.eraser, 1'b0) > 30) begin
      r = $urandom_range(2, 1);
      void'(sb.visit_footprint(cx, cy, r, sb.eraser, 1'b0));
    end
    holes = sb.missing_pixels;
    foreach (holes[k]) begin
      if (!sb.background_set[holes[k]]) begin
        send_item(ACT_WRITE, X_W'($urandom), Y_W'($urandom), RAD_W'($urandom),
                  COLOR_W'($urandom), ADDR_W'(holes[k]));
      end
    end
    repeat ($urandom_range(2)) send_stamp(cx, cy, $urandom_range(8), COLOR_W'($urandom));
    send_stamp(cx, cy, r, sb.eraser);
    repeat ($urandom_range(3, 1)) begin
      a = sb.pixel_at(cx - r + $urandom_range(2 * r - 1), cy - r + $urandom_range(2 * r - 1));
      send_item(ACT_READ, X_W'($urandom), Y_W'($urandom), RAD_W'($urandom),
                COLOR_W'($urandom), sb.canvas_set[a] ? ADDR_W'(a) : pick_read_addr());
    end
  endtask

  // One standalone random transaction of any kind.
  task automatic send_random_single();
    int pick;
    int q;
    int a;
    int h;
    int cx;
    int cy;
    bit [COLOR_W-1:0] color;
    pick = $urandom_range(99);
    q    = $urandom_range(99);
    if (pick < 35) begin
      if (q < 70) a = hot_pixel();
      else if (q < 90) a = $urandom_range(PIX_N - 1);
      else a = $urandom_range(ADDR_SPAN - 1, PIX_N);
      send_item(ACT_WRITE, X_W'($urandom), Y_W'($urandom), RAD_W'($urandom),
                COLOR_W'($urandom), ADDR_W'(a));
    end else if (pick < 55) begin
      send_item(ACT_READ, X_W'($urandom), Y_W'($urandom), RAD_W'($urandom),
                COLOR_W'($urandom), pick_read_addr());
    end else if (pick < 95) begin
      if (q < 50) begin
        h  = $urandom_range(HOT_COUNT - 1);
        cx = HOT_X[h] + $urandom_range(HOT_SIZE - 1);
        cy = HOT_Y[h] + $urandom_range(HOT_SIZE - 1);
      end else if (q < 85) begin
        cx = $urandom_range(X_SPAN - 1);
        cy = $urandom_range(Y_SPAN - 1);
      end else begin
        case ($urandom_range(2))
          0:       cx = 0;
          1:       cx = SCR_W - 1;
          default: cx = $urandom_range(X_SPAN - 1, SCR_W);
        endcase
        cy = $urandom_range(Y_SPAN - 1);
      end
      color = COLOR_W'($urandom);
      if ($urandom_range(99) < 25) color = sb.eraser;
      send_stamp(cx, cy, pick_radius(), color);
    end else begin
      send_item(ACT_UNUSED, X_W'($urandom), Y_W'($urandom), RAD_W'($urandom),
                COLOR_W'($urandom), ADDR_W'($urandom));
    end
  endtask

  initial begin : stimulus
    bit [COLOR_W-1:0] eraser_plan [3];
    sb          = new();
    rst_ni      = 1'b0;
    psel        = 1'b0;
    penable     = 1'b0;
    pwrite      = 1'b0;
    paddr       = '0;
    pwdata      = '0;
    in_valid_i  = 1'b0;
    action_i    = '0;
    center_x_i  = '0;
    center_y_i  = '0;
    radius_i    = '0;
    color_i     = '0;
    address_i   = '0;
    out_stall_i = 1'b0;
    eraser_plan = '{16'hFFFF, COLOR_W'($urandom), 16'h0000};
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed checks run at the reset eraser color.
    send_idle_pct = 10;
    recv_idle_pct = 88;
    run_directed();

    // Three random phases, each with its own eraser color and idle pattern.
    for (int phase = 0; phase < 3; phase++) begin
      wait_drained();
      set_eraser(eraser_plan[phase]);
      send_idle_pct = (phase == 0) ? 10 : (phase == 1) ? 88 : 0;
      recv_idle_pct = (phase == 0) ? 88 : (phase == 1) ? 10 : 0;
      while (items_sent < ITEM_GOAL * (phase + 1) / 3) begin
        if ($urandom_range(99) < 40) send_brush_session();
        else send_random_single();
      end
    end

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    $display("Ran %0d transactions: %0d stamps (%0d restoring), %0d writes, %0d reads.",
             items_sent, sb.n_stamps, sb.n_restores, sb.n_writes, sb.n_reads);
    $display("Compared %0d results; %0d canvas pixels painted; eraser color set %0d times.",
             sb.n_checked, sb.pixels_painted, eraser_settings);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
